### src/bse_pkg.sv
// shared constants, request codes, transaction types and helpers for the bitmap set engine
package bse_pkg;

    // storage geometry
    localparam int NUM_SETS      = 4;
    localparam int WORDS_PER_SET = 128;
    localparam int WORD_BITS     = 32;
    localparam int BIT_W         = 5;
    localparam int TOTAL_WORDS   = NUM_SETS * WORDS_PER_SET;
    localparam int ADDR_W        = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
    localparam int WIDX_W        = (WORDS_PER_SET > 1) ? $clog2(WORDS_PER_SET) : 1;
    localparam int CAPACITY      = WORDS_PER_SET * WORD_BITS;

    // request codes
    localparam logic [2:0] REQ_FIND      = 3'd0;
    localparam logic [2:0] REQ_INSERT    = 3'd1;
    localparam logic [2:0] REQ_REMOVE    = 3'd2;
    localparam logic [2:0] REQ_CLEAR     = 3'd3;
    localparam logic [2:0] REQ_EMPTY     = 3'd4;
    localparam logic [2:0] REQ_UNION     = 3'd5;
    localparam logic [2:0] REQ_INTERSECT = 3'd6;

    // request transaction
    typedef struct packed {
        logic [2:0]  req_type;
        logic [1:0]  set_id;
        logic [1:0]  src_a;
        logic [1:0]  src_b;
        logic [15:0] value;
    } t_req;

    // result transaction
    typedef struct packed {
        logic found;
        logic set_empty;
        logic status;
    } t_rsp;

    // port controls of the bitmap memory
    typedef struct packed {
        logic                  rd_a_en;
        logic [ADDR_W-1:0]     rd_a_addr;
        logic                  rd_b_en;
        logic [ADDR_W-1:0]     rd_b_addr;
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [WORD_BITS-1:0]  wr_data;
    } t_ram_ctl;

    // flat word address of one word of one set
    function automatic logic [ADDR_W-1:0] f_addr(input logic [1:0] set_sel,
                                                 input logic [WIDX_W-1:0] word);
        f_addr = ADDR_W'(int'(set_sel) * WORDS_PER_SET + int'(word));
    endfunction

    // set index names an existing set
    function automatic logic f_set_ok(input logic [1:0] set_sel);
        f_set_ok = (int'(set_sel) < NUM_SETS);
    endfunction

    // value lies inside the fixed capacity
    function automatic logic f_in_cap(input logic [15:0] value);
        f_in_cap = ({1'b0, value} < 17'(CAPACITY));
    endfunction

    // word index of a value within its set
    function automatic logic [WIDX_W-1:0] f_word_idx(input logic [15:0] value);
        f_word_idx = WIDX_W'(value[15:BIT_W]);
    endfunction

endpackage

### src/bse_ram.sv
// bitmap word memory: two registered read ports, one write port
module bse_ram (
    input  logic                                 i_clk,
    input  bse_pkg::t_ram_ctl                    i_ctl,
    output logic [bse_pkg::WORD_BITS-1:0]        o_rd_a,
    output logic [bse_pkg::WORD_BITS-1:0]        o_rd_b
);

    logic [bse_pkg::WORD_BITS-1:0] mem [bse_pkg::TOTAL_WORDS];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
    end

    // read ports, data held until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_a_en) begin
            o_rd_a <= mem[i_ctl.rd_a_addr];
        end
        if (i_ctl.rd_b_en) begin
            o_rd_b <= mem[i_ctl.rd_b_addr];
        end
    end

endmodule

### src/bitmap_set_engine.sv
// top level of the bitmap set engine: request sequencer around the bitmap memory
//
// Request channel i_valid / o_ready carries i_req; result channel o_valid / i_ready
// carries o_rsp. Every request transaction yields exactly one result transaction,
// in request order.
// Find, insert and remove do one read-modify-write of a single memory word: the
// word is read at acceptance and written back in the next cycle, where the result
// is also loaded into the output register if that register is free.
// Clear, empty test, union and intersect walk every word of the set through a
// two-stage read / combine-and-write pipeline on the two read ports and the
// write port; the empty test only reads and writes nothing back.
// One request is in progress at a time; o_ready is high only while idle.
// The result register decouples the two sides: a new request is taken while a
// result still waits; if the receiver stalls longer, the next request finishes
// its memory work and then holds until the result register frees up.
// After reset a clearing pass writes zero to all TOTAL_WORDS words
// (NUM_SETS * WORDS_PER_SET = 512 words), with o_ready low throughout.
// An insert beyond capacity is dropped and reported with status set.
module bitmap_set_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bse_pkg::t_req   i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output bse_pkg::t_rsp   o_rsp
);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_POINT = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_RESP  = 3'd4;

    localparam logic [bse_pkg::WIDX_W-1:0] LAST_IDX =
        bse_pkg::WIDX_W'(bse_pkg::WORDS_PER_SET - 1);
    localparam logic [bse_pkg::ADDR_W-1:0] LAST_ADDR =
        bse_pkg::ADDR_W'(bse_pkg::TOTAL_WORDS - 1);

    // control registers
    logic [2:0]                   r_state, n_state;
    logic [bse_pkg::ADDR_W-1:0]   r_init_addr, n_init_addr;
    logic                         r_issue, n_issue;
    logic                         r_p_vld, n_p_vld;
    logic                         r_out_valid, n_out_valid;

    // payload registers
    bse_pkg::t_req                r_req, n_req;
    logic                         r_a_ok, n_a_ok;
    logic                         r_b_ok, n_b_ok;
    logic                         r_d_ok, n_d_ok;
    logic                         r_cap, n_cap;
    logic [bse_pkg::WIDX_W-1:0]   r_idx, n_idx;
    logic [bse_pkg::WIDX_W-1:0]   r_p_idx, n_p_idx;
    logic                         r_p_last, n_p_last;
    logic                         r_any, n_any;
    bse_pkg::t_rsp                r_res, n_res;
    bse_pkg::t_rsp                r_out, n_out;

    bse_pkg::t_ram_ctl            ram_ctl;
    logic [bse_pkg::WORD_BITS-1:0] rd_a, rd_b;
    logic [bse_pkg::WORD_BITS-1:0] a_word, b_word, bit_mask;
    logic                          in_acc, out_free, out_load, fin_vld;
    logic                          is_walk, is_pair;
    bse_pkg::t_rsp                 fin_rsp;

    bse_ram u_ram (
        .i_clk  (i_clk),
        .i_ctl  (ram_ctl),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    assign o_ready  = (r_state == ST_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_rsp    = r_out;

    // source words, nonexistent sets read as empty
    assign a_word   = r_a_ok ? rd_a : '0;
    assign b_word   = r_b_ok ? rd_b : '0;
    assign bit_mask = bse_pkg::WORD_BITS'(32'h1) << r_req.value[bse_pkg::BIT_W-1:0];

    assign is_pair  = (r_req.req_type == bse_pkg::REQ_UNION) ||
                      (r_req.req_type == bse_pkg::REQ_INTERSECT);
    assign is_walk  = (i_req.req_type == bse_pkg::REQ_CLEAR) ||
                      (i_req.req_type == bse_pkg::REQ_EMPTY) ||
                      (i_req.req_type == bse_pkg::REQ_UNION) ||
                      (i_req.req_type == bse_pkg::REQ_INTERSECT);

    // sequencer, memory port control and result computation
    always_comb begin
        n_state     = r_state;
        n_init_addr = r_init_addr;
        n_issue     = r_issue;
        n_p_vld     = 1'b0;
        n_req       = r_req;
        n_a_ok      = r_a_ok;
        n_b_ok      = r_b_ok;
        n_d_ok      = r_d_ok;
        n_cap       = r_cap;
        n_idx       = r_idx;
        n_p_idx     = r_idx;
        n_p_last    = (r_idx == LAST_IDX);
        n_any       = r_any;
        n_res       = r_res;
        fin_vld     = 1'b0;
        fin_rsp     = '0;
        ram_ctl     = '0;

        case (r_state)
            ST_INIT: begin
                ram_ctl.wr_en   = 1'b1;
                ram_ctl.wr_addr = r_init_addr;
                ram_ctl.wr_data = '0;
                n_init_addr     = r_init_addr + bse_pkg::ADDR_W'(1);
                if (r_init_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // read the addressed word of the target set at acceptance
                ram_ctl.rd_a_en   = in_acc;
                ram_ctl.rd_a_addr = bse_pkg::f_addr(i_req.set_id,
                                                    bse_pkg::f_word_idx(i_req.value));
                if (in_acc) begin
                    n_req  = i_req;
                    n_d_ok = bse_pkg::f_set_ok(i_req.set_id);
                    n_cap  = bse_pkg::f_in_cap(i_req.value);
                    n_b_ok = bse_pkg::f_set_ok(i_req.src_b);
                    if ((i_req.req_type == bse_pkg::REQ_UNION) ||
                        (i_req.req_type == bse_pkg::REQ_INTERSECT)) begin
                        n_a_ok = bse_pkg::f_set_ok(i_req.src_a);
                    end else begin
                        n_a_ok = bse_pkg::f_set_ok(i_req.set_id);
                    end
                    n_idx   = '0;
                    n_any   = 1'b0;
                    n_issue = is_walk;
                    n_state = is_walk ? ST_WALK : ST_POINT;
                end
            end
            ST_POINT: begin
                // modify and write back the single word
                fin_vld = 1'b1;
                case (r_req.req_type)
                    bse_pkg::REQ_FIND: begin
                        fin_rsp.found = r_cap && |(a_word & bit_mask);
                    end
                    bse_pkg::REQ_INSERT: begin
                        fin_rsp.status  = !r_cap;
                        ram_ctl.wr_en   = r_cap && r_d_ok;
                        ram_ctl.wr_addr = bse_pkg::f_addr(r_req.set_id,
                                                          bse_pkg::f_word_idx(r_req.value));
                        ram_ctl.wr_data = rd_a | bit_mask;
                    end
                    bse_pkg::REQ_REMOVE: begin
                        ram_ctl.wr_en   = r_cap && r_d_ok;
                        ram_ctl.wr_addr = bse_pkg::f_addr(r_req.set_id,
                                                          bse_pkg::f_word_idx(r_req.value));
                        ram_ctl.wr_data = rd_a & ~bit_mask;
                    end
                    default: begin
                    end
                endcase
            end
            ST_WALK: begin
                // stage one: read word r_idx of the sources
                ram_ctl.rd_a_en   = r_issue;
                ram_ctl.rd_a_addr = bse_pkg::f_addr(is_pair ? r_req.src_a : r_req.set_id,
                                                    r_idx);
                ram_ctl.rd_b_en   = r_issue;
                ram_ctl.rd_b_addr = bse_pkg::f_addr(r_req.src_b, r_idx);
                n_p_vld           = r_issue;
                if (r_issue) begin
                    if (r_idx == LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + bse_pkg::WIDX_W'(1);
                    end
                end
                // stage two: combine, write back, accumulate occupancy
                if (r_p_vld) begin
                    ram_ctl.wr_en   = r_d_ok && (r_req.req_type != bse_pkg::REQ_EMPTY);
                    ram_ctl.wr_addr = bse_pkg::f_addr(r_req.set_id, r_p_idx);
                    case (r_req.req_type)
                        bse_pkg::REQ_UNION:     ram_ctl.wr_data = a_word | b_word;
                        bse_pkg::REQ_INTERSECT: ram_ctl.wr_data = a_word & b_word;
                        default:                ram_ctl.wr_data = '0;
                    endcase
                    n_any = r_any || (a_word != '0);
                    if (r_p_last) begin
                        fin_vld           = 1'b1;
                        fin_rsp.set_empty = (r_req.req_type == bse_pkg::REQ_EMPTY) &&
                                            !(r_any || (a_word != '0));
                    end
                end
            end
            ST_RESP: begin
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // hand the finished result to the output register or park it
        if (fin_vld) begin
            n_res   = fin_rsp;
            n_state = out_free ? ST_IDLE : ST_RESP;
        end else if (r_state == ST_RESP && out_free) begin
            n_state = ST_IDLE;
        end
    end

    // output register
    always_comb begin
        out_load    = (fin_vld || (r_state == ST_RESP)) && out_free;
        n_out       = fin_vld ? fin_rsp : r_res;
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_init_addr <= '0;
            r_issue     <= 1'b0;
            r_p_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_addr <= n_init_addr;
            r_issue     <= n_issue;
            r_p_vld     <= n_p_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_a_ok   <= n_a_ok;
        r_b_ok   <= n_b_ok;
        r_d_ok   <= n_d_ok;
        r_cap    <= n_cap;
        r_idx    <= n_idx;
        r_p_idx  <= n_p_idx;
        r_p_last <= n_p_last;
        r_any    <= n_any;
        r_res    <= n_res;
        if (out_load) begin
            r_out <= n_out;
        end
    end

    // a write never lands on a word being read in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_ctl.wr_en && ram_ctl.rd_a_en) |-> (ram_ctl.wr_addr != ram_ctl.rd_a_addr))
        else $error("write and read of the same word overlap");

    // the single-word update state ST_POINT is always followed by ST_IDLE or ST_RESP
    a_point_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POINT) |=> ((r_state == ST_IDLE) || (r_state == ST_RESP)))
        else $error("single-word update did not finish");

    // the walk pipeline drains completely after the last word
    a_walk_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && r_p_vld && r_p_last) |=> (!r_p_vld && !r_issue))
        else $error("walk pipeline busy after last word");

    // a dropped-insert flag only comes from an insert transaction
    a_status_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_out.status) |-> (r_req.req_type == bse_pkg::REQ_INSERT))
        else $error("status set on a non-insert transaction");

endmodule

### sim/bitmap_set_engine_tb.sv
// testbench for the bitmap set engine: directed table, then random requests checked against a shadow bitmap
`timescale 1ns / 1ps

module bitmap_set_engine_tb;

    localparam logic [2:0] REQ_UNUSED = 3'd7;

    localparam int CAP           = bse_pkg::CAPACITY;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = bse_pkg::WORDS_PER_SET + 12;
    localparam int RANDOM_ITEMS  = 450;
    localparam int SEGMENT_ITEMS = 50;
    localparam int MAX_REPORTS   = 10;

    // typed-in results, fields ordered found / set_empty / status
    localparam bse_pkg::t_rsp RSP_NONE    = 3'b000;
    localparam bse_pkg::t_rsp RSP_FOUND   = 3'b100;
    localparam bse_pkg::t_rsp RSP_EMPTY   = 3'b010;
    localparam bse_pkg::t_rsp RSP_DROPPED = 3'b001;

    // one row of the directed table
    typedef struct packed {
        bse_pkg::t_req req;
        logic          typed;
        bse_pkg::t_rsp rsp;
    } t_dir_row;

    logic          i_clk;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    bse_pkg::t_req i_req   = '0;
    logic          i_ready = 1'b0;
    logic          o_ready;
    logic          o_valid;
    bse_pkg::t_rsp o_rsp;

    bit [bse_pkg::WORD_BITS-1:0] shadow_bitmap [bse_pkg::NUM_SETS][bse_pkg::WORDS_PER_SET];
    bse_pkg::t_rsp               pending_rsp_q [$];
    t_dir_row                    dir_rows [$];
    int                          mismatch_count = 0;
    int                          cycle_count = 0;
    bit                          idling_on = 1'b0;

    bitmap_set_engine i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // word of a set, nonexistent sets and words read as zero
    function automatic bit [bse_pkg::WORD_BITS-1:0] stored_word(input logic [1:0] sel,
                                                                input int idx);
        if (int'(sel) >= bse_pkg::NUM_SETS || idx >= bse_pkg::WORDS_PER_SET)
            return '0;
        return shadow_bitmap[sel][idx];
    endfunction

    // apply one request to the shadow bitmap and return the result it gives
    function automatic bse_pkg::t_rsp apply_set_request(input bse_pkg::t_req r);
        bse_pkg::t_rsp               rsp;
        int                          word_i;
        int                          w;
        bit [bse_pkg::WORD_BITS-1:0] bit_mask;
        bit [bse_pkg::WORD_BITS-1:0] wa;
        bit [bse_pkg::WORD_BITS-1:0] wb;
        bit                          in_range;
        bit                          dest_ok;
        rsp      = RSP_NONE;
        in_range = int'(r.value) < CAP;
        dest_ok  = int'(r.set_id) < bse_pkg::NUM_SETS;
        word_i   = int'(r.value) / bse_pkg::WORD_BITS;
        bit_mask = 32'h1 << (int'(r.value) % bse_pkg::WORD_BITS);
        case (r.req_type)
            bse_pkg::REQ_FIND: begin
                if (in_range)
                    rsp.found = |(stored_word(r.set_id, word_i) & bit_mask);
            end
            bse_pkg::REQ_INSERT: begin
                if (!in_range)
                    rsp.status = 1'b1;
                else if (dest_ok)
                    shadow_bitmap[r.set_id][word_i] |= bit_mask;
            end
            bse_pkg::REQ_REMOVE: begin
                if (in_range && dest_ok)
                    shadow_bitmap[r.set_id][word_i] &= ~bit_mask;
            end
            bse_pkg::REQ_CLEAR: begin
                if (dest_ok)
                    for (w = 0; w < bse_pkg::WORDS_PER_SET; w++)
                        shadow_bitmap[r.set_id][w] = '0;
            end
            bse_pkg::REQ_EMPTY: begin
                rsp.set_empty = 1'b1;
                for (w = 0; w < bse_pkg::WORDS_PER_SET; w++)
                    if (stored_word(r.set_id, w) != '0)
                        rsp.set_empty = 1'b0;
            end
            bse_pkg::REQ_UNION, bse_pkg::REQ_INTERSECT: begin
                // combined word by word, so a destination that is also a source works
                if (dest_ok)
                    for (w = 0; w < bse_pkg::WORDS_PER_SET; w++) begin
                        wa = stored_word(r.src_a, w);
                        wb = stored_word(r.src_b, w);
                        shadow_bitmap[r.set_id][w] =
                            (r.req_type == bse_pkg::REQ_UNION) ? (wa | wb) : (wa & wb);
                    end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    // append one directed request
    function automatic void add_row(input logic [2:0] op, input int sid, input int a,
                                    input int b, input int val, input logic typed,
                                    input bse_pkg::t_rsp rsp);
        t_dir_row row;
        row.req.req_type = op;
        row.req.set_id   = 2'(sid);
        row.req.src_a    = 2'(a);
        row.req.src_b    = 2'(b);
        row.req.value    = 16'(val);
        row.typed        = typed;
        row.rsp          = rsp;
        dir_rows.push_back(row);
    endfunction

    // random request, half of the values packed low so finds and removes hit members
    function automatic bse_pkg::t_req random_request();
        bse_pkg::t_req r;
        int            pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            r.req_type = bse_pkg::REQ_INSERT;
        else if (pick < 54)
            r.req_type = bse_pkg::REQ_FIND;
        else if (pick < 67)
            r.req_type = bse_pkg::REQ_REMOVE;
        else if (pick < 75)
            r.req_type = bse_pkg::REQ_EMPTY;
        else if (pick < 84)
            r.req_type = bse_pkg::REQ_UNION;
        else if (pick < 92)
            r.req_type = bse_pkg::REQ_INTERSECT;
        else if (pick < 96)
            r.req_type = bse_pkg::REQ_CLEAR;
        else
            r.req_type = REQ_UNUSED;
        r.set_id = 2'($urandom_range(0, 3));
        r.src_a  = 2'($urandom_range(0, 3));
        r.src_b  = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: r.value = 16'($urandom_range(0, 95));
            5, 6, 7:       r.value = 16'($urandom_range(0, CAP - 1));
            default:       r.value = 16'($urandom_range(0, 65535));
        endcase
        return r;
    endfunction

    function automatic void report_mismatch(input string what, input bse_pkg::t_rsp want,
                                            input bse_pkg::t_rsp got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch (%s) at cycle %0d: expected found=%0b empty=%0b status=%0b, %s",
                     what, cycle_count, want.found, want.set_empty, want.status,
                     $sformatf("got found=%0b empty=%0b status=%0b",
                               got.found, got.set_empty, got.status));
    endfunction

    // present one request transaction and record its expected result at acceptance
    task automatic send_request(input bse_pkg::t_req r, input logic typed,
                                input bse_pkg::t_rsp typed_rsp);
        bse_pkg::t_rsp predicted;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        predicted = apply_set_request(r);
        pending_rsp_q.push_back(typed ? typed_rsp : predicted);
    endtask

    // result side stalls
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (idling_on && $urandom_range(0, 5) == 0) begin
                stall   = $urandom_range(1, 18);
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // compare each result transaction with the oldest pending expectation
    always @(posedge i_clk) begin
        bse_pkg::t_rsp want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (pending_rsp_q.size() == 0) begin
                report_mismatch("result with nothing pending", RSP_NONE, o_rsp);
            end else begin
                want = pending_rsp_q.pop_front();
                if (o_rsp.found !== want.found || o_rsp.set_empty !== want.set_empty ||
                    o_rsp.status !== want.status)
                    report_mismatch("result fields", want, o_rsp);
            end
        end
    end

    // stimulus
    initial begin
        int seg;
        int n;
        //      request                 set a  b  value    typed result
        // empty after reset
        add_row(bse_pkg::REQ_FIND,      0, 0, 0, 0,       1'b1, RSP_NONE);
        add_row(bse_pkg::REQ_EMPTY,     3, 0, 0, 0,       1'b1, RSP_EMPTY);
        add_row(bse_pkg::REQ_INSERT,    0, 0, 0, 0,       1'b1, RSP_NONE);
        // top of capacity
        add_row(bse_pkg::REQ_INSERT,    0, 0, 0, CAP - 1, 1'b1, RSP_NONE);
        // first value beyond
        add_row(bse_pkg::REQ_INSERT,    1, 0, 0, CAP,     1'b1, RSP_DROPPED);
        add_row(bse_pkg::REQ_INSERT,    2, 0, 0, 65535,   1'b1, RSP_DROPPED);
        add_row(bse_pkg::REQ_FIND,      0, 0, 0, 0,       1'b1, RSP_FOUND);
        add_row(bse_pkg::REQ_FIND,      0, 0, 0, CAP - 1, 1'b1, RSP_FOUND);
        // beyond capacity
        add_row(bse_pkg::REQ_FIND,      1, 0, 0, CAP,     1'b1, RSP_NONE);
        add_row(bse_pkg::REQ_FIND,      2, 0, 0, 65535,   1'b1, RSP_NONE);
        // ignored
        add_row(bse_pkg::REQ_REMOVE,    0, 0, 0, 65535,   1'b0, RSP_NONE);
        add_row(bse_pkg::REQ_FIND,      0, 0, 0, 31,      1'b0, RSP_NONE);
        add_row(bse_pkg::REQ_INSERT,    1, 0, 0, 'h0AAA,  1'b0, RSP_NONE);
        add_row(bse_pkg::REQ_INSERT,    1, 0, 0, 'h0555,  1'b0, RSP_NONE);
        add_row(bse_pkg::REQ_EMPTY,     0, 0, 0, 0,       1'b0, RSP_NONE);
        add_row(bse_pkg::REQ_UNION,     2, 0, 1, 0,       1'b0, RSP_NONE);
        add_row(bse_pkg::REQ_INTERSECT, 3, 0, 2, 0,       1'b0, RSP_NONE);
        add_row(bse_pkg::REQ_FIND,      3, 0, 0, CAP - 1, 1'b0, RSP_NONE);
        // in place union
        add_row(bse_pkg::REQ_UNION,     1, 1, 0, 0,       1'b0, RSP_NONE);
        // in place intersect
        add_row(bse_pkg::REQ_INTERSECT, 0, 0, 3, 0,       1'b0, RSP_NONE);
        add_row(bse_pkg::REQ_REMOVE,    0, 0, 0, 0,       1'b0, RSP_NONE);
        add_row(bse_pkg::REQ_FIND,      0, 0, 0, 0,       1'b0, RSP_NONE);
        add_row(bse_pkg::REQ_CLEAR,     2, 0, 0, 0,       1'b0, RSP_NONE);
        add_row(bse_pkg::REQ_EMPTY,     2, 0, 0, 0,       1'b0, RSP_NONE);
        // unused code, no effect
        add_row(REQ_UNUSED,             3, 3, 3, 65535,   1'b1, RSP_NONE);
        add_row(bse_pkg::REQ_FIND,      1, 0, 0, 'h0555,  1'b0, RSP_NONE);

        // reset, then the block clears its memory with o_ready low
        repeat (3) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        idling_on = 1'b1;

        foreach (dir_rows[k])
            send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].rsp);

        // random part in segments, some without idling, the last one never idles
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            seg       = n / SEGMENT_ITEMS;
            idling_on = (seg < RANDOM_ITEMS / SEGMENT_ITEMS - 1) && (seg % 3 != 1);
            send_request(random_request(), 1'b0, RSP_NONE);
        end
        i_valid <= 1'b0;

        // drain
        while (pending_rsp_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_rsp_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
